/* src/ang_pkg.sv */
// shared types, widths, register indexes and reset values for the audio noise gate
package ang_pkg;

	localparam int DATA_W     = 24;
	localparam int ENV_W      = 23;
	localparam int COEF_W     = 16;
	localparam int GAIN_W     = 17;
	localparam int HOLD_W     = 20;
	localparam int CCNT_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = DATA_W + 1;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int MAX_CHANNELS_DEF = 2;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_THRESH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES  = 3'd5;

	// register reset values
	localparam logic                RST_ENABLED       = 1'b1;
	localparam logic [CCNT_W-1:0]   RST_CHANNEL_COUNT = 2'd2;
	localparam logic [ENV_W-1:0]    RST_UPPER_THRESH  = 23'd26527;
	localparam logic [COEF_W-1:0]   RST_ATTACK_COEFF  = 16'd136;
	localparam logic [COEF_W-1:0]   RST_RELEASE_COEFF = 16'd14;
	localparam logic [HOLD_W-1:0]   RST_HOLD_SAMPLES  = 20'd2400;

	typedef struct packed {
		logic              enabled;
		logic [CCNT_W-1:0] channel_count;
		logic [ENV_W-1:0]  upper_threshold;
		logic [COEF_W-1:0] attack_coeff;
		logic [COEF_W-1:0] release_coeff;
		logic [HOLD_W-1:0] hold_samples;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENV_PREP,
		ST_ENV_MUL,
		ST_ENV_UPD,
		ST_GAIN_MUL,
		ST_GAIN_UPD,
		ST_OUT0_MUL,
		ST_OUT1_MUL,
		ST_OUT_CAP,
		ST_DONE
	} state_t;

endpackage

/* src/ang_in_if.sv */
// input channel: one audio frame per word
interface ang_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [ang_pkg::DATA_W-1:0]   sample_first;
	logic signed [ang_pkg::DATA_W-1:0]   sample_second;

	modport source (output valid, output sample_first, output sample_second, input ready);
	modport sink   (input valid, input sample_first, input sample_second, output ready);
endinterface

/* src/ang_out_if.sv */
// output channel: one gated frame per word
interface ang_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ang_pkg::DATA_W-1:0]   gated_first;
	logic signed [ang_pkg::DATA_W-1:0]   gated_second;
	logic                                gate_open;

	modport source (output valid, output gated_first, output gated_second, output gate_open,
		input ready);
	modport sink   (input valid, input gated_first, input gated_second, input gate_open,
		output ready);
endinterface

/* src/audio_noise_gate_top.sv */
// Audio noise gate with hold. Each word on frame_in is one frame of up to two Q1.23
// samples; each word on frame_out is the gated frame and the gate decision. With the gate
// enabled the sequencer uses one shared 25x18 multiplier four times in turn (envelope
// step, gain step, first and second sample) before loading the result into the output
// register; with the gate disabled it goes straight to its done state. A new frame is
// accepted as soon as the sequencer is idle, also while the last result still waits in
// the output register, but not while a frame is still in the sequencer. The user must
// write registers through cfg_we, cfg_index and cfg_wdata only while no frame is in
// flight; the block itself does not enforce this.
module audio_noise_gate_top #(
	parameter int MAX_CHANNELS = ang_pkg::MAX_CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	ang_in_if.sink                           frame_in,
	ang_out_if.source                        frame_out,
	input  logic                             cfg_we,
	input  logic [ang_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ang_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	ang_pkg::cfg_t cfg;

	ang_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ang_core #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.frame_in  (frame_in),
		.frame_out (frame_out)
	);

endmodule

/* src/ang_cfg_regs.sv */
// configuration register file with plain write port
module ang_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ang_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ang_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output ang_pkg::cfg_t                    cfg
);

	ang_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled         <= ang_pkg::RST_ENABLED;
			cfg_q.channel_count   <= ang_pkg::RST_CHANNEL_COUNT;
			cfg_q.upper_threshold <= ang_pkg::RST_UPPER_THRESH;
			cfg_q.attack_coeff    <= ang_pkg::RST_ATTACK_COEFF;
			cfg_q.release_coeff   <= ang_pkg::RST_RELEASE_COEFF;
			cfg_q.hold_samples    <= ang_pkg::RST_HOLD_SAMPLES;
		end else if (cfg_we) begin
			case (cfg_index)
				ang_pkg::REG_ENABLED:       cfg_q.enabled <= cfg_wdata[0];
				ang_pkg::REG_CHANNEL_COUNT:
					cfg_q.channel_count <= cfg_wdata[ang_pkg::CCNT_W-1:0];
				ang_pkg::REG_UPPER_THRESH:
					cfg_q.upper_threshold <= cfg_wdata[ang_pkg::ENV_W-1:0];
				ang_pkg::REG_ATTACK_COEFF:
					cfg_q.attack_coeff <= cfg_wdata[ang_pkg::COEF_W-1:0];
				ang_pkg::REG_RELEASE_COEFF:
					cfg_q.release_coeff <= cfg_wdata[ang_pkg::COEF_W-1:0];
				ang_pkg::REG_HOLD_SAMPLES:
					cfg_q.hold_samples <= cfg_wdata[ang_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/ang_mul.sv */
// shared signed multiplier with registered product
module ang_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [ang_pkg::MUL_A_W-1:0]  a,
	input  logic signed [ang_pkg::MUL_B_W-1:0]  b,
	output logic signed [ang_pkg::MUL_P_W-1:0]  prod
);

	logic signed [ang_pkg::MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

/* src/ang_core.sv */
// sequencer and datapath: envelope, hold, gain smoothing and output scaling
module ang_core #(
	parameter int MAX_CHANNELS = ang_pkg::MAX_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ang_pkg::cfg_t      cfg,
	ang_in_if.sink             frame_in,
	ang_out_if.source          frame_out
);

	localparam int DW = ang_pkg::DATA_W;
	localparam int EW = ang_pkg::ENV_W;
	localparam int GW = ang_pkg::GAIN_W;
	localparam int CW = ang_pkg::COEF_W;
	localparam int HW = ang_pkg::HOLD_W;
	localparam int AW = ang_pkg::MUL_A_W;
	localparam int BW = ang_pkg::MUL_B_W;
	localparam int PW = ang_pkg::MUL_P_W;

	// magnitude of a sample, the most negative value saturating to full scale
	function automatic logic [EW-1:0] mag23(input logic signed [DW-1:0] s);
		logic [DW-1:0] n;
		n = -s;
		if (!s[DW-1]) begin
			return s[EW-1:0];
		end else if (n[DW-1]) begin
			return '1;
		end else begin
			return n[EW-1:0];
		end
	endfunction

	ang_pkg::state_t state_q, state_d;

	logic signed [DW-1:0] s0_q, s1_q;
	logic [EW-1:0]        mag0_q, mag1_q;
	logic                 ch2_q;
	logic                 up_q;
	logic [CW-1:0]        coeff_q;
	logic [EW-1:0]        diff_q;
	logic [EW-1:0]        env_q;
	logic [GW-1:0]        gain_q;
	logic [HW-1:0]        hold_q;
	logic                 open_q;
	logic signed [DW-1:0] res0_q, res1_q;

	logic                 out_valid_q;
	logic signed [DW-1:0] out_first_q, out_second_q;
	logic                 out_open_q;

	logic                 mul_en;
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod;

	logic                 accept;
	logic                 out_load;
	logic                 ch2_in;
	logic [EW-1:0]        peak;
	logic                 peak_above;
	logic [EW-1:0]        env_step;
	logic [EW-1:0]        env_next;
	logic                 thr_hit;
	logic                 hold_live;
	logic [GW-1:0]        gain_diff;
	logic [GW-1:0]        gain_step;
	logic [GW-1:0]        gain_next;

	ang_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign ch2_in   = (MAX_CHANNELS > 1) && cfg.channel_count[1];
	assign accept   = frame_in.valid && frame_in.ready;
	assign out_load = (state_q == ang_pkg::ST_DONE) && (!out_valid_q || frame_out.ready);

	assign peak       = (ch2_q && (mag1_q > mag0_q)) ? mag1_q : mag0_q;
	assign peak_above = peak > env_q;

	assign env_step  = prod[EW+CW-1:CW];
	assign env_next  = up_q ? env_q + env_step : env_q - env_step;
	assign thr_hit   = env_next > cfg.upper_threshold;
	assign hold_live = hold_q != '0;

	assign gain_diff = open_q ? ang_pkg::GAIN_ONE - gain_q : gain_q;
	assign gain_step = prod[GW+CW-1:CW];
	assign gain_next = open_q ? gain_q + gain_step : gain_q - gain_step;

	always_comb begin
		state_d        = state_q;
		mul_en         = 1'b0;
		mul_a          = '0;
		mul_b          = '0;
		frame_in.ready = (state_q == ang_pkg::ST_IDLE);
		case (state_q)
			ang_pkg::ST_IDLE: begin
				if (frame_in.valid) begin
					state_d = cfg.enabled ? ang_pkg::ST_ENV_PREP : ang_pkg::ST_DONE;
				end
			end
			ang_pkg::ST_ENV_PREP: state_d = ang_pkg::ST_ENV_MUL;
			ang_pkg::ST_ENV_MUL: begin
				mul_en  = 1'b1;
				mul_a   = AW'(diff_q);
				mul_b   = BW'(coeff_q);
				state_d = ang_pkg::ST_ENV_UPD;
			end
			ang_pkg::ST_ENV_UPD: state_d = ang_pkg::ST_GAIN_MUL;
			ang_pkg::ST_GAIN_MUL: begin
				mul_en  = 1'b1;
				mul_a   = AW'(gain_diff);
				mul_b   = BW'(coeff_q);
				state_d = ang_pkg::ST_GAIN_UPD;
			end
			ang_pkg::ST_GAIN_UPD: state_d = ang_pkg::ST_OUT0_MUL;
			ang_pkg::ST_OUT0_MUL: begin
				mul_en  = 1'b1;
				mul_a   = AW'(s0_q);
				mul_b   = BW'(gain_q);
				state_d = ang_pkg::ST_OUT1_MUL;
			end
			ang_pkg::ST_OUT1_MUL: begin
				mul_en  = 1'b1;
				mul_a   = AW'(s1_q);
				mul_b   = BW'(gain_q);
				state_d = ang_pkg::ST_OUT_CAP;
			end
			ang_pkg::ST_OUT_CAP: state_d = ang_pkg::ST_DONE;
			ang_pkg::ST_DONE: begin
				if (!out_valid_q || frame_out.ready) begin
					state_d = ang_pkg::ST_IDLE;
				end
			end
			default: state_d = ang_pkg::ST_IDLE;
		endcase
	end

	// control state and the gate's running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ang_pkg::ST_IDLE;
			env_q       <= '0;
			gain_q      <= '0;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ang_pkg::ST_ENV_UPD) begin
				env_q <= env_next;
				if (thr_hit) begin
					hold_q <= cfg.hold_samples;
				end else if (hold_live) begin
					hold_q <= hold_q - HW'(1);
				end
			end
			if (state_q == ang_pkg::ST_GAIN_UPD) begin
				gain_q <= gain_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (frame_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per-frame payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s0_q   <= frame_in.sample_first;
			s1_q   <= frame_in.sample_second;
			mag0_q <= mag23(frame_in.sample_first);
			mag1_q <= mag23(frame_in.sample_second);
			ch2_q  <= ch2_in;
			// pass-through result, overwritten later when the gate is applied
			res0_q <= frame_in.sample_first;
			res1_q <= ch2_in ? frame_in.sample_second : '0;
			open_q <= 1'b0;
		end
		if (state_q == ang_pkg::ST_ENV_PREP) begin
			up_q    <= peak >= env_q;
			coeff_q <= peak_above ? cfg.attack_coeff : cfg.release_coeff;
			diff_q  <= (peak >= env_q) ? peak - env_q : env_q - peak;
		end
		if (state_q == ang_pkg::ST_ENV_UPD) begin
			open_q <= thr_hit || hold_live;
		end
		if (state_q == ang_pkg::ST_OUT1_MUL) begin
			res0_q <= prod[DW+CW-1:CW];
		end
		if (state_q == ang_pkg::ST_OUT_CAP) begin
			res1_q <= ch2_q ? prod[DW+CW-1:CW] : '0;
		end
		if (out_load) begin
			out_first_q  <= res0_q;
			out_second_q <= res1_q;
			out_open_q   <= open_q;
		end
	end

	assign frame_out.valid        = out_valid_q;
	assign frame_out.gated_first  = out_first_q;
	assign frame_out.gated_second = out_second_q;
	assign frame_out.gate_open    = out_open_q;

endmodule
